// ----- rtl/bknpl_pkg.sv -----
// ----------------------------------------------------------------------------
// bknpl_pkg
// Shared constants and types for the bounded k-nearest pixel list.
// ----------------------------------------------------------------------------
package bknpl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int COORD_BITS  = 12;
    localparam int DIST_BITS   = 24;

    // held count and capacity fields are fixed at 5 bits
    localparam int HELD_BITS = 5;
    localparam int CAP_BITS  = 5;
    localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
    localparam int WIDE_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] column;
        logic [DIST_BITS-1:0]  distance;
    } t_entry;

    typedef struct packed {
        logic compare;
        logic load;
        logic take_prev;
        logic take_next;
    } t_cell_ctrl;

    typedef struct packed {
        logic match;
        logic greater;
    } t_cell_flags;

endpackage

// ----- rtl/bknpl_cell.sv -----
// ----------------------------------------------------------------------------
// bknpl_cell
// One list slot: holds an entry, compares it with the request, and loads
// the request or a neighbor's entry.
// ----------------------------------------------------------------------------
module bknpl_cell (
    input  logic                   i_clk,
    input  bknpl_pkg::t_cell_ctrl  i_ctrl,
    input  logic                   i_occupied,
    input  bknpl_pkg::t_entry      i_req,
    input  bknpl_pkg::t_entry      i_prev,
    input  bknpl_pkg::t_entry      i_next,
    output bknpl_pkg::t_entry      o_entry,
    output bknpl_pkg::t_cell_flags o_flags
);

    bknpl_pkg::t_entry      r_entry;
    bknpl_pkg::t_cell_flags r_flags;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.compare) begin
            r_flags.match   <= i_occupied && (r_entry.row == i_req.row)
                               && (r_entry.column == i_req.column);
            r_flags.greater <= i_occupied && (r_entry.distance > i_req.distance);
        end
        if (i_ctrl.load) begin
            r_entry <= i_req;
        end else if (i_ctrl.take_prev) begin
            r_entry <= i_prev;
        end else if (i_ctrl.take_next) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

// ----- rtl/bounded_k_nearest_pixel_list.sv -----
// ----------------------------------------------------------------------------
// bounded_k_nearest_pixel_list
// Sorted list of nearest pixels built as a row of cells, with insert/update
// and extract-minimum requests.
// ----------------------------------------------------------------------------
// channel  | direction | handshake              | payload
// request  | in        | i_req_valid/o_req_ready | mode, pixel row/column/distance
// result   | out       | o_res_valid/i_res_ready | pixel, flags, held count
// config   | in/out    | APB psel/penable        | capacity_limit at byte 0
//
// A request goes through capture, compare in every cell, then one
// shift of the cell row; the next request is taken after the update.
// The update waits while the previous result is still held in the output
// register. Reset (synchronous, active low) empties the list and loads the
// capacity with 16; cell contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_k_nearest_pixel_list (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_req_valid,
    output logic                                    o_req_ready,
    input  logic                                    i_mode,
    input  logic [bknpl_pkg::COORD_BITS-1:0]        i_pixel_row,
    input  logic [bknpl_pkg::COORD_BITS-1:0]        i_pixel_column,
    input  logic [bknpl_pkg::DIST_BITS-1:0]         i_pixel_distance,
    output logic                                    o_res_valid,
    input  logic                                    i_res_ready,
    output logic                                    o_out_valid,
    output logic [bknpl_pkg::COORD_BITS-1:0]        o_out_row,
    output logic [bknpl_pkg::COORD_BITS-1:0]        o_out_column,
    output logic [bknpl_pkg::DIST_BITS-1:0]         o_out_distance,
    output logic                                    o_empty_error,
    output logic [bknpl_pkg::HELD_BITS-1:0]         o_held_count,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [bknpl_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [bknpl_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [bknpl_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                    pready
);

    localparam int N = bknpl_pkg::MAX_ENTRIES;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPARE = 2'd1;
    localparam logic [1:0] ST_UPDATE  = 2'd2;

    logic [1:0]                          r_state, n_state;
    logic                                r_mode;
    bknpl_pkg::t_entry                   r_req;
    logic [bknpl_pkg::CNT_BITS-1:0]      r_count, n_count;
    logic [bknpl_pkg::CAP_BITS-1:0]      r_cap_limit;
    logic [bknpl_pkg::CAP_BITS-1:0]      r_remaining, n_remaining;

    logic                                r_res_valid;
    logic                                r_out_valid;
    bknpl_pkg::t_entry                   r_out;
    logic                                r_empty_error;
    logic [bknpl_pkg::HELD_BITS-1:0]     r_held;

    bknpl_pkg::t_entry                   w_entry [N];
    bknpl_pkg::t_cell_flags              w_flags [N];
    bknpl_pkg::t_cell_ctrl               w_ctrl  [N];
    logic [N-1:0]                        w_occ, w_match, w_greater, w_first_q;
    logic [N-1:0]                        w_after_q, w_upto_p, w_match_below;
    logic [bknpl_pkg::WIDE_BITS-1:0]     w_cap_eff, w_count_wide;

    logic w_fire, w_empty, w_full, w_any_match, w_match_gt, w_any_gt;
    logic w_do_ins, w_grow, w_do_ext, w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == bknpl_pkg::REG_CAPACITY);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == bknpl_pkg::REG_CAPACITY)
                      ? bknpl_pkg::APB_DATA_BITS'(r_cap_limit) : '0;

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_fire      = (r_state == ST_UPDATE) && (!r_res_valid || i_res_ready);

    // per-cell occupancy and flags
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_occ[i]     = (bknpl_pkg::CNT_BITS'(i) < r_count);
            w_match[i]   = w_flags[i].match;
            w_greater[i] = w_flags[i].greater;
        end
    end

    assign w_empty      = (r_count == '0);
    assign w_count_wide = bknpl_pkg::WIDE_BITS'(r_count);
    assign w_cap_eff    = (bknpl_pkg::WIDE_BITS'(r_remaining) > bknpl_pkg::WIDE_BITS'(N))
                          ? bknpl_pkg::WIDE_BITS'(N) : bknpl_pkg::WIDE_BITS'(r_remaining);
    assign w_full       = (w_count_wide >= w_cap_eff);
    assign w_any_match  = |w_match;
    assign w_match_gt   = |(w_match & w_greater);
    assign w_any_gt     = |w_greater;

    assign w_do_ext = (r_mode == bknpl_pkg::MODE_EXTRACT) && !w_empty;
    assign w_do_ins = (r_mode == bknpl_pkg::MODE_INSERT)
                      && (w_empty || (w_any_match ? w_match_gt : (!w_full || w_any_gt)));
    assign w_grow   = w_empty || (!w_any_match && !w_full);

    // insert slot q: first greater or free cell; vacated slot p: match, last or end
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_match_below[i] = |(w_match & ((N'(1) << i) - N'(1)));
            w_after_q[i]     = w_greater[i] || !w_occ[i];
            if (w_empty) begin
                w_upto_p[i] = (i == 0);
            end else if (w_any_match) begin
                w_upto_p[i] = !w_match_below[i];
            end else if (w_grow) begin
                w_upto_p[i] = (bknpl_pkg::CNT_BITS'(i) <= r_count);
            end else begin
                w_upto_p[i] = w_occ[i];
            end
        end
        w_first_q[0] = w_after_q[0];
        for (int i = 1; i < N; i++) begin
            w_first_q[i] = w_after_q[i] && !w_after_q[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_ctrl[i].compare   = (r_state == ST_COMPARE);
            w_ctrl[i].load      = w_fire && w_do_ins && w_upto_p[i] && w_first_q[i];
            w_ctrl[i].take_prev = w_fire && w_do_ins && w_upto_p[i] && w_after_q[i]
                                  && !w_first_q[i];
            w_ctrl[i].take_next = w_fire && w_do_ext && (i < N - 1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            bknpl_pkg::t_entry w_prev, w_next;
            if (g == 0) begin : g_head
                assign w_prev = r_req;
            end else begin : g_body
                assign w_prev = w_entry[g-1];
            end
            if (g == N - 1) begin : g_tail
                assign w_next = w_entry[g];
            end else begin : g_inner
                assign w_next = w_entry[g+1];
            end
            bknpl_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl[g]),
                .i_occupied (w_occ[g]),
                .i_req      (r_req),
                .i_prev     (w_prev),
                .i_next     (w_next),
                .o_entry    (w_entry[g]),
                .o_flags    (w_flags[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_remaining = r_remaining;
        if (w_do_ins && w_grow) begin
            n_count = r_count + bknpl_pkg::CNT_BITS'(1);
        end
        if (w_do_ext) begin
            n_count = r_count - bknpl_pkg::CNT_BITS'(1);
            if (r_remaining != '0) begin
                n_remaining = r_remaining - bknpl_pkg::CAP_BITS'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cap_limit <= bknpl_pkg::CAP_RESET;
            r_remaining <= bknpl_pkg::CAP_RESET;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_cap_limit <= pwdata[bknpl_pkg::CAP_BITS-1:0];
                r_remaining <= pwdata[bknpl_pkg::CAP_BITS-1:0];
            end else if (w_fire) begin
                r_remaining <= n_remaining;
            end
            if (w_fire) begin
                r_count     <= n_count;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_mode         <= i_mode;
            r_req.row      <= i_pixel_row;
            r_req.column   <= i_pixel_column;
            r_req.distance <= i_pixel_distance;
        end
        if (w_fire) begin
            r_out_valid   <= w_do_ext;
            r_out         <= w_do_ext ? w_entry[0] : '0;
            r_empty_error <= (r_mode == bknpl_pkg::MODE_EXTRACT) && w_empty;
            r_held        <= bknpl_pkg::HELD_BITS'(n_count);
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_out_valid    = r_out_valid;
    assign o_out_row      = r_out.row;
    assign o_out_column   = r_out.column;
    assign o_out_distance = r_out.distance;
    assign o_empty_error  = r_empty_error;
    assign o_held_count   = r_held;

endmodule

// ----- rtl/bknpl_checker.sv -----
// ----------------------------------------------------------------------------
// bknpl_port_checks
// Port-level checks for the bounded k-nearest pixel list.
// ----------------------------------------------------------------------------
module bknpl_port_checks (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_res_valid,
    input logic                               i_res_ready,
    input logic                               o_out_valid,
    input logic [bknpl_pkg::COORD_BITS-1:0]   o_out_row,
    input logic [bknpl_pkg::COORD_BITS-1:0]   o_out_column,
    input logic [bknpl_pkg::DIST_BITS-1:0]    o_out_distance,
    input logic                               o_empty_error,
    input logic [bknpl_pkg::HELD_BITS-1:0]    o_held_count
);

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_out_valid && o_empty_error))
        else $error("pixel returned together with empty error");

    a_empty_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_out_valid) |->
        (o_out_row == '0) && (o_out_column == '0) && (o_out_distance == '0))
        else $error("pixel fields not zero without a returned pixel");

    a_error_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_empty_error) |-> (o_held_count == '0))
        else $error("empty error with pixels held");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_held_count <= bknpl_pkg::HELD_BITS'(bknpl_pkg::MAX_ENTRIES)))
        else $error("held count above storage");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> o_res_valid && $stable(o_held_count)
        && $stable(o_out_distance) && $stable(o_out_valid))
        else $error("stalled result changed");

endmodule

bind bounded_k_nearest_pixel_list bknpl_port_checks u_bknpl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_out_valid    (o_out_valid),
    .o_out_row      (o_out_row),
    .o_out_column   (o_out_column),
    .o_out_distance (o_out_distance),
    .o_empty_error  (o_empty_error),
    .o_held_count   (o_held_count)
);
